// ===== rtl/hgg_pkg.sv =====
`timescale 1ns / 1ps
package hgg_pkg;

    localparam int WIRE_COUNT = 1024;
    localparam int WIRE_W = $clog2(WIRE_COUNT);

    localparam logic [2:0] MODE_XOR    = 3'd0;
    localparam logic [2:0] MODE_XNOR   = 3'd1;
    localparam logic [2:0] MODE_NOT    = 3'd2;
    localparam logic [2:0] MODE_HALF   = 3'd3;
    localparam logic [2:0] MODE_LOAD   = 3'd4;
    localparam logic [2:0] MODE_COPY   = 3'd5;
    localparam logic [2:0] MODE_READ   = 3'd6;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam logic [1:0] REG_KEY_HI   = 2'd0;
    localparam logic [1:0] REG_KEY_LO   = 2'd1;
    localparam logic [1:0] REG_DELTA_HI = 2'd2;
    localparam logic [1:0] REG_DELTA_LO = 2'd3;

    typedef logic [127:0] blk_t;

    // request to the shared aes round unit
    typedef struct packed {
        logic start;
        blk_t data;
    } aes_req_t;

    typedef struct packed {
        logic done;
        blk_t hash;
    } aes_rsp_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte j of the state sits at bits 8j+7:8j
    function automatic blk_t sub_shift(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[8*(j+4*c) +: 8] = SBOX[s[8*(j+4*((c+j)%4)) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic blk_t mix_columns(input blk_t t);
        blk_t o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c)   +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            o[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            o[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            o[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            o[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

    // one step of the key schedule: next round key from the previous one
    function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
        blk_t n;
        logic [31:0] t;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
             SBOX[k[111:104]] ^ rc};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

endpackage

// ===== rtl/hgg_ram.sv =====
`timescale 1ns / 1ps
module hgg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/hgg_aes.sv =====
`timescale 1ns / 1ps
// iterated aes-128 round unit computing H(x) = AES(x) ^ x, one round per cycle
module hgg_aes (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            key_load,
    input  hgg_pkg::blk_t   key,
    input  hgg_pkg::aes_req_t req,
    output hgg_pkg::aes_rsp_t rsp,
    output logic            key_busy
);

    typedef enum logic [1:0] {S_IDLE, S_KEYX, S_RUN} state_t;

    state_t        state_reg;
    logic [3:0]    round_reg;
    hgg_pkg::blk_t rk_reg [11];
    hgg_pkg::blk_t st_reg;
    hgg_pkg::blk_t x_reg;
    logic          done_reg;
    hgg_pkg::blk_t sub;
    hgg_pkg::blk_t mixed;
    hgg_pkg::blk_t rk_next;

    assign sub     = hgg_pkg::sub_shift(st_reg);
    assign mixed   = (round_reg == 4'd10) ? sub : hgg_pkg::mix_columns(sub);
    assign rk_next = hgg_pkg::key_step(rk_reg[round_reg - 4'd1], hgg_pkg::RCON[round_reg - 4'd1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= 4'd0;
            done_reg  <= 1'b0;
            for (int i = 0; i < 11; i++)
            begin
                rk_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (key_load)
            begin
                // a new key restarts the expansion, also when one is running
                rk_reg[0] <= key;
                round_reg <= 4'd1;
                state_reg <= S_KEYX;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (req.start)
                        begin
                            st_reg    <= req.data ^ rk_reg[0];
                            x_reg     <= req.data;
                            round_reg <= 4'd1;
                            state_reg <= S_RUN;
                        end
                    end
                    S_KEYX:
                    begin
                        // expand one round key per cycle
                        rk_reg[round_reg] <= rk_next;
                        if (round_reg == 4'd10)
                        begin
                            state_reg <= S_IDLE;
                        end
                        round_reg <= round_reg + 4'd1;
                    end
                    S_RUN:
                    begin
                        st_reg <= mixed ^ rk_reg[round_reg];
                        if (round_reg == 4'd10)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        round_reg <= round_reg + 4'd1;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hash = st_reg ^ x_reg;
    assign key_busy = (state_reg == S_KEYX);

    busy_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> !req.start)
        else $error("hash start while busy");
    done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(state_reg == S_RUN && round_reg == 4'd10))
        else $error("hash done without final round");
    round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (round_reg >= 4'd1 && round_reg <= 4'd10))
        else $error("round counter out of range");

endmodule

// ===== rtl/half_gates_garbler_top.sv =====
`timescale 1ns / 1ps
// after the input transfer a load writes the store at once; other modes read the source
// pairs first, and a half-gate runs four hashes; throughput: one item at a time, ready
// again on return to idle, after the last result transfer for read and half-gate; the
// label store has one read and one write port of 64 bits, so a pair takes four accesses
// reset: asynchronous active low, clears control, key and offset registers and round
// keys; the label store is not cleared and a key write holds off input until keys expand
module half_gates_garbler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [2:0]  inversions,
    input  logic [9:0]  wire_a,
    input  logic [9:0]  wire_b,
    input  logic [9:0]  wire_out,
    input  logic [31:0] gate_index,
    input  logic [31:0] cycle_index,
    input  logic [63:0] label0_hi,
    input  logic [63:0] label0_lo,
    input  logic [63:0] label1_hi,
    input  logic [63:0] label1_lo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] word_hi,
    output logic [63:0] word_lo,
    output logic        slot,
    output logic        last
);

    localparam int AW = hgg_pkg::WIRE_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_HASH, S_HWAIT, S_WR, S_OUT0, S_OUT1
    } state_t;

    state_t        state_reg;
    logic [2:0]    mode_reg;
    logic [2:0]    inv_reg;
    logic [hgg_pkg::WIRE_W-1:0] wa_reg, wb_reg, wo_reg;
    logic [63:0]   tw_lo_reg, tw_hi_reg;
    logic [63:0]   key_hi_reg, key_lo_reg, delta_hi_reg, delta_lo_reg;
    hgg_pkg::blk_t a0_reg, a1_reg, b0_reg, b1_reg;
    hgg_pkg::blk_t m_reg [4];
    hgg_pkg::blk_t w0_reg, w1_reg, t0_reg, t1_reg;
    logic [3:0]    cnt_reg;
    logic [1:0]    hidx_reg;
    logic          key_load_reg;
    logic          aes_key_busy;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    hgg_pkg::aes_req_t aes_req;
    hgg_pkg::aes_rsp_t aes_rsp;

    hgg_pkg::blk_t A0, A1, B0, B1, R, t0, t1, hin;
    hgg_pkg::blk_t T0, T1, G, E, X;

    hgg_ram #(.WIDTH(64), .DEPTH(hgg_pkg::WIRE_COUNT * 4)) u_labels (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hgg_aes u_aes (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_load (key_load_reg),
        .key      ({key_hi_reg, key_lo_reg}),
        .req      (aes_req),
        .rsp      (aes_rsp),
        .key_busy (aes_key_busy)
    );

    assign R  = {delta_hi_reg, delta_lo_reg};
    assign A0 = inv_reg[0] ? a1_reg : a0_reg;
    assign A1 = inv_reg[0] ? a0_reg : a1_reg;
    assign B0 = inv_reg[1] ? b1_reg : b0_reg;
    assign B1 = inv_reg[1] ? b0_reg : b1_reg;
    assign t0 = {tw_hi_reg, tw_lo_reg};
    assign t1 = {tw_hi_reg, tw_lo_reg | 64'd1};

    always_comb
    begin
        case (hidx_reg)
            2'd0:    hin = A0 ^ t0;
            2'd1:    hin = A1 ^ t0;
            2'd2:    hin = B0 ^ t1;
            default: hin = B1 ^ t1;
        endcase
    end

    assign aes_req.start = (state_reg == S_HASH);
    assign aes_req.data  = hin;

    assign T0 = m_reg[0] ^ m_reg[1] ^ (B0[0] ? R : '0);
    assign G  = A0[0] ? (m_reg[0] ^ T0) : m_reg[0];
    assign T1 = m_reg[2] ^ m_reg[3] ^ A0;
    assign E  = B0[0] ? (m_reg[2] ^ T1 ^ A0) : m_reg[2];
    assign X  = G ^ E;

    // read address: cnt 0..7 walks a0 hi/lo, a1 hi/lo, then b
    assign ram_raddr = cnt_reg[2] ? {wb_reg, cnt_reg[1:0]} : {wa_reg, cnt_reg[1:0]};
    assign ram_we    = (state_reg == S_WR);
    assign ram_waddr = {wo_reg, cnt_reg[1:0]};

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    ram_wdata = w0_reg[127:64];
            2'd1:    ram_wdata = w0_reg[63:0];
            2'd2:    ram_wdata = w1_reg[127:64];
            default: ram_wdata = w1_reg[63:0];
        endcase
    end

    // no transfer while a config register is written or a key is expanded
    assign in_ready  = (state_reg == S_IDLE) && !cfg_we && !key_load_reg && !aes_key_busy;
    assign out_valid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign slot      = (state_reg == S_OUT1);
    assign last      = (state_reg == S_OUT1);
    assign word_hi   = (state_reg == S_OUT1) ? w1_reg[127:64] : w0_reg[127:64];
    assign word_lo   = (state_reg == S_OUT1) ? w1_reg[63:0] : w0_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= 4'd0;
            hidx_reg     <= 2'd0;
            key_load_reg <= 1'b0;
            key_hi_reg   <= '0;
            key_lo_reg   <= '0;
            delta_hi_reg <= '0;
            delta_lo_reg <= '0;
        end
        else
        begin
            key_load_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hgg_pkg::REG_KEY_HI:
                    begin
                        key_hi_reg   <= cfg_data;
                        key_load_reg <= 1'b1;
                    end
                    hgg_pkg::REG_KEY_LO:
                    begin
                        key_lo_reg   <= cfg_data;
                        key_load_reg <= 1'b1;
                    end
                    hgg_pkg::REG_DELTA_HI: delta_hi_reg <= cfg_data;
                    hgg_pkg::REG_DELTA_LO: delta_lo_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg  <= mode;
                        inv_reg   <= inversions;
                        wa_reg    <= wire_a[hgg_pkg::WIRE_W-1:0];
                        wb_reg    <= wire_b[hgg_pkg::WIRE_W-1:0];
                        wo_reg    <= wire_out[hgg_pkg::WIRE_W-1:0];
                        tw_hi_reg <= {32'd0, cycle_index};
                        tw_lo_reg <= {31'd0, gate_index, 1'b0};
                        w0_reg    <= {label0_hi, label0_lo};
                        w1_reg    <= {label1_hi, label1_lo};
                        cnt_reg   <= 4'd0;
                        hidx_reg  <= 2'd0;
                        if (mode == hgg_pkg::MODE_LOAD)
                        begin
                            state_reg <= S_WR;
                        end
                        else if (mode != hgg_pkg::MODE_UNUSED)
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    // data for address issued last cycle lands now
                    if (cnt_reg != 4'd0)
                    begin
                        unique case (cnt_reg[2:0] - 3'd1)
                            3'd0: a0_reg[127:64] <= ram_rdata;
                            3'd1: a0_reg[63:0]   <= ram_rdata;
                            3'd2: a1_reg[127:64] <= ram_rdata;
                            3'd3: a1_reg[63:0]   <= ram_rdata;
                            3'd4: b0_reg[127:64] <= ram_rdata;
                            3'd5: b0_reg[63:0]   <= ram_rdata;
                            3'd6: b1_reg[127:64] <= ram_rdata;
                            default: b1_reg[63:0] <= ram_rdata;
                        endcase
                    end
                    if (cnt_reg == 4'd8)
                    begin
                        state_reg <= S_WAIT;
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                S_WAIT:
                begin
                    cnt_reg <= 4'd0;
                    unique case (mode_reg)
                        hgg_pkg::MODE_XOR:
                        begin
                            w0_reg <= a0_reg ^ b0_reg;
                            w1_reg <= a1_reg ^ b0_reg;
                            state_reg <= S_WR;
                        end
                        hgg_pkg::MODE_XNOR:
                        begin
                            w0_reg <= a1_reg ^ b0_reg;
                            w1_reg <= a0_reg ^ b0_reg;
                            state_reg <= S_WR;
                        end
                        hgg_pkg::MODE_NOT:
                        begin
                            w0_reg <= a1_reg;
                            w1_reg <= a0_reg;
                            state_reg <= S_WR;
                        end
                        hgg_pkg::MODE_COPY:
                        begin
                            w0_reg <= a0_reg;
                            w1_reg <= a1_reg;
                            state_reg <= S_WR;
                        end
                        hgg_pkg::MODE_READ:
                        begin
                            w0_reg <= a0_reg;
                            w1_reg <= a1_reg;
                            state_reg <= S_OUT0;
                        end
                        default:
                        begin
                            state_reg <= S_HASH;
                        end
                    endcase
                end
                S_HASH:
                begin
                    state_reg <= S_HWAIT;
                end
                S_HWAIT:
                begin
                    if (aes_rsp.done)
                    begin
                        m_reg[hidx_reg] <= aes_rsp.hash;
                        hidx_reg        <= hidx_reg + 2'd1;
                        if (hidx_reg == 2'd3)
                        begin
                            state_reg <= S_WR;
                            cnt_reg   <= 4'd0;
                        end
                        else
                        begin
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_WR:
                begin
                    if (mode_reg == hgg_pkg::MODE_HALF && cnt_reg == 4'd0)
                    begin
                        // latch the table rows and output pair, write next cycle
                        w0_reg    <= inv_reg[2] ? (X ^ R) : X;
                        w1_reg    <= inv_reg[2] ? X : (X ^ R);
                        t0_reg    <= T0;
                        t1_reg    <= T1;
                        mode_reg  <= hgg_pkg::MODE_READ;
                        state_reg <= S_WR;
                    end
                    else
                    begin
                        if (cnt_reg[1:0] == 2'd3)
                        begin
                            if (mode_reg == hgg_pkg::MODE_READ)
                            begin
                                w0_reg    <= t0_reg;
                                w1_reg    <= t1_reg;
                                state_reg <= S_OUT0;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        cnt_reg <= {2'd0, cnt_reg[1:0] + 2'd1};
                    end
                end
                S_OUT0:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_OUT1;
                    end
                end
                S_OUT1:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input ready while busy");
    last_follows_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> (out_valid && last))
        else $error("second result missing");
    no_write_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !ram_we)
        else $error("store written during output");

endmodule

// ===== tb/sv/half_gates_garbler_checker.sv =====
`timescale 1ns / 1ps
module half_gates_garbler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [2:0]  inversions,
    input  logic [9:0]  wire_a,
    input  logic [9:0]  wire_b,
    input  logic [9:0]  wire_out,
    input  logic [31:0] gate_index,
    input  logic [31:0] cycle_index,
    input  logic [63:0] label0_hi,
    input  logic [63:0] label0_lo,
    input  logic [63:0] label1_hi,
    input  logic [63:0] label1_lo,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] word_hi,
    input  logic [63:0] word_lo,
    input  logic        slot,
    input  logic        last,
    output int          errors,
    output int          rows_pending,
    output int          rows_checked,
    output int          half_gates_seen
);

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        slot;
        logic        last;
    } row_t;

    row_t         rows_due[$];
    logic [7:0]   sb [256];
    logic [127:0] rk [11];
    logic [127:0] lab0 [1024];
    logic [127:0] lab1 [1024];
    logic [63:0]  key_hi_q, key_lo_q;
    logic [127:0] delta;

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = dbl(a);
        end
        return p;
    endfunction

    // sbox from the field inverse and the affine map
    initial
    begin
        logic [7:0] inv_b, s;
        for (int x = 0; x < 256; x++)
        begin
            inv_b = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01)
                    inv_b = y[7:0];
            s = inv_b ^ {inv_b[6:0], inv_b[7]} ^ {inv_b[5:0], inv_b[7:6]}
                ^ {inv_b[4:0], inv_b[7:5]} ^ {inv_b[3:0], inv_b[7:4]} ^ 8'h63;
            sb[x] = s;
        end
    end

    task automatic expand_key();
        logic [7:0]   kb [176];
        logic [7:0]   t0, t1, t2, t3, sv, rc;
        logic [127:0] k;
        k = {key_hi_q, key_lo_q};
        rc = 8'h01;
        for (int j = 0; j < 16; j++)
            kb[j] = k[8*j +: 8];
        for (int i = 16; i < 176; i += 4)
        begin
            t0 = kb[i-4]; t1 = kb[i-3]; t2 = kb[i-2]; t3 = kb[i-1];
            if (i % 16 == 0)
            begin
                sv = t0;
                t0 = sb[t1] ^ rc;
                t1 = sb[t2];
                t2 = sb[t3];
                t3 = sb[sv];
                rc = dbl(rc);
            end
            kb[i]   = kb[i-16] ^ t0;
            kb[i+1] = kb[i-15] ^ t1;
            kb[i+2] = kb[i-14] ^ t2;
            kb[i+3] = kb[i-13] ^ t3;
        end
        for (int r = 0; r < 11; r++)
            for (int j = 0; j < 16; j++)
                rk[r][8*j +: 8] = kb[16*r + j];
    endtask

    // aes of x under the current round keys, folded back with x
    function automatic logic [127:0] tweak_hash(input logic [127:0] x);
        logic [127:0] s, t;
        logic [7:0]   a0, a1, a2, a3, al;
        s = x ^ rk[0];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    t[8*(j+4*c) +: 8] = sb[s[8*(j+4*((c+j)%4)) +: 8]];
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[8*(4*c) +: 8];
                    a1 = t[8*(4*c+1) +: 8];
                    a2 = t[8*(4*c+2) +: 8];
                    a3 = t[8*(4*c+3) +: 8];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[8*(4*c) +: 8]   = a0 ^ al ^ dbl(a0 ^ a1);
                    t[8*(4*c+1) +: 8] = a1 ^ al ^ dbl(a1 ^ a2);
                    t[8*(4*c+2) +: 8] = a2 ^ al ^ dbl(a2 ^ a3);
                    t[8*(4*c+3) +: 8] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            s = t ^ rk[r];
        end
        return s ^ x;
    endfunction

    task automatic push_row(input logic [127:0] v, input logic which);
        row_t r;
        r.hi = v[127:64];
        r.lo = v[63:0];
        r.slot = which;
        r.last = which;
        rows_due.push_back(r);
    endtask

    task automatic garble_item();
        logic [127:0] a0, a1, b0, b1, ga0, ga1, gb0, gb1, tw0, tw1;
        logic [127:0] m0, m1, m2, m3, row0, row1, g_half, e_half, x;
        a0 = lab0[wire_a]; a1 = lab1[wire_a];
        b0 = lab0[wire_b]; b1 = lab1[wire_b];
        case (mode)
            hgg_pkg::MODE_XOR:
            begin
                lab0[wire_out] = a0 ^ b0;
                lab1[wire_out] = a1 ^ b0;
            end
            hgg_pkg::MODE_XNOR:
            begin
                lab0[wire_out] = a1 ^ b0;
                lab1[wire_out] = a0 ^ b0;
            end
            hgg_pkg::MODE_NOT:
            begin
                lab0[wire_out] = a1;
                lab1[wire_out] = a0;
            end
            hgg_pkg::MODE_HALF:
            begin
                ga0 = inversions[0] ? a1 : a0;
                ga1 = inversions[0] ? a0 : a1;
                gb0 = inversions[1] ? b1 : b0;
                gb1 = inversions[1] ? b0 : b1;
                tw0 = {32'h0, cycle_index, 31'h0, gate_index, 1'b0};
                tw1 = tw0 | 128'h1;
                m0 = tweak_hash(ga0 ^ tw0);
                m1 = tweak_hash(ga1 ^ tw0);
                m2 = tweak_hash(gb0 ^ tw1);
                m3 = tweak_hash(gb1 ^ tw1);
                row0 = m0 ^ m1 ^ (gb0[0] ? delta : 128'h0);
                g_half = ga0[0] ? (m0 ^ row0) : m0;
                row1 = m2 ^ m3 ^ ga0;
                e_half = gb0[0] ? (m2 ^ row1 ^ ga0) : m2;
                x = g_half ^ e_half;
                lab0[wire_out] = inversions[2] ? (x ^ delta) : x;
                lab1[wire_out] = inversions[2] ? x : (x ^ delta);
                push_row(row0, 1'b0);
                push_row(row1, 1'b1);
                half_gates_seen++;
            end
            hgg_pkg::MODE_LOAD:
            begin
                lab0[wire_out] = {label0_hi, label0_lo};
                lab1[wire_out] = {label1_hi, label1_lo};
            end
            hgg_pkg::MODE_COPY:
            begin
                lab0[wire_out] = a0;
                lab1[wire_out] = a1;
            end
            hgg_pkg::MODE_READ:
            begin
                push_row(a0, 1'b0);
                push_row(a1, 1'b1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        if (errors <= 30)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        row_t w;
        if (!rst_n)
        begin
            key_hi_q = '0;
            key_lo_q = '0;
            delta = '0;
            for (int r = 0; r < 11; r++)
                rk[r] = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hgg_pkg::REG_KEY_HI:
                    begin
                        key_hi_q = cfg_data;
                        expand_key();
                    end
                    hgg_pkg::REG_KEY_LO:
                    begin
                        key_lo_q = cfg_data;
                        expand_key();
                    end
                    hgg_pkg::REG_DELTA_HI: delta[127:64] = cfg_data;
                    hgg_pkg::REG_DELTA_LO: delta[63:0] = cfg_data;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (rows_due.size() == 0)
                    report("unexpected transfer", word_lo, 64'h0);
                else
                begin
                    w = rows_due.pop_front();
                    if (word_hi !== w.hi)
                        report("word_hi", word_hi, w.hi);
                    if (word_lo !== w.lo)
                        report("word_lo", word_lo, w.lo);
                    if (slot !== w.slot)
                        report("slot", {63'h0, slot}, {63'h0, w.slot});
                    if (last !== w.last)
                        report("last", {63'h0, last}, {63'h0, w.last});
                    rows_checked++;
                end
            end
            if (in_valid && in_ready)
                garble_item();
        end
        rows_pending = rows_due.size();
    end

endmodule

// ===== tb/sv/half_gates_garbler_top_test.sv =====
`timescale 1ns / 1ps
module half_gates_garbler_top_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    logic [2:0]  inversions = '0;
    logic [9:0]  wire_a = '0;
    logic [9:0]  wire_b = '0;
    logic [9:0]  wire_out = '0;
    logic [31:0] gate_index = '0;
    logic [31:0] cycle_index = '0;
    logic [63:0] label0_hi = '0;
    logic [63:0] label0_lo = '0;
    logic [63:0] label1_hi = '0;
    logic [63:0] label1_lo = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] word_hi;
    logic [63:0] word_lo;
    logic        slot;
    logic        last;

    int errors, rows_pending, rows_checked, half_gates_seen;
    int cycles = 0;
    int items_sent = 0;
    int send_idle = 0;
    int recv_idle = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;

    bit         written [1024];
    logic [9:0] written_q[$];
    logic [9:0] recent_q[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    half_gates_garbler_top dut (.*);

    half_gates_garbler_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req)
        begin
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic logic [63:0] any_word();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] any_index();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // source wires come only from the ones already written
    function automatic logic [9:0] pick_wire();
        if (recent_q.size() > 0 && $urandom_range(0, 1))
            return recent_q[$urandom_range(0, recent_q.size() - 1)];
        return written_q[$urandom_range(0, written_q.size() - 1)];
    endfunction

    task automatic send(input logic [2:0] m, input logic [2:0] inv, input logic [9:0] a,
                        input logic [9:0] b, input logic [9:0] o, input logic [31:0] g,
                        input logic [31:0] cy, input logic [63:0] l0h, input logic [63:0] l0l,
                        input logic [63:0] l1h, input logic [63:0] l1l);
        if (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        mode <= m;
        inversions <= inv;
        wire_a <= a;
        wire_b <= b;
        wire_out <= o;
        gate_index <= g;
        cycle_index <= cy;
        label0_hi <= l0h;
        label0_lo <= l0l;
        label1_hi <= l1h;
        label1_lo <= l1l;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (m <= hgg_pkg::MODE_COPY)
        begin
            if (!written[o])
                written_q.push_back(o);
            written[o] = 1'b1;
            recent_q.push_back(o);
            if (recent_q.size() > 8)
                void'(recent_q.pop_front());
        end
    endtask

    task automatic send_random();
        int       pick;
        logic [2:0] m;
        pick = $urandom_range(0, 99);
        if (pick < 35)      m = hgg_pkg::MODE_HALF;
        else if (pick < 50) m = hgg_pkg::MODE_READ;
        else if (pick < 60) m = hgg_pkg::MODE_XOR;
        else if (pick < 67) m = hgg_pkg::MODE_XNOR;
        else if (pick < 74) m = hgg_pkg::MODE_NOT;
        else if (pick < 82) m = hgg_pkg::MODE_COPY;
        else if (pick < 95) m = hgg_pkg::MODE_LOAD;
        else                m = hgg_pkg::MODE_UNUSED;
        send(m, 3'($urandom_range(0, 7)), pick_wire(), pick_wire(),
             10'($urandom_range(0, 1023)), any_index(), any_index(),
             any_word(), any_word(), any_word(), any_word());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (rows_pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] kh, input logic [63:0] kl,
                              input logic [63:0] dh, input logic [63:0] dl);
        write_reg(hgg_pkg::REG_KEY_HI, kh);
        write_reg(hgg_pkg::REG_KEY_LO, kl);
        write_reg(hgg_pkg::REG_DELTA_HI, dh);
        write_reg(hgg_pkg::REG_DELTA_LO, dl);
        cfg_we <= 1'b0;
        // key schedule expands in the background
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero key and zero offset, extremes and aliasing
        send(hgg_pkg::MODE_LOAD, 3'd0, 10'd0, 10'd0, 10'd0, 32'h0, 32'h0,
             64'h0, 64'h0, '1, '1);
        send(hgg_pkg::MODE_LOAD, 3'd7, 10'd0, 10'd0, 10'd1023, 32'h0, 32'h0,
             '1, '1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send(hgg_pkg::MODE_LOAD, 3'd0, 10'd0, 10'd0, 10'd1, 32'h0, 32'h0,
             64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3211,
             64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0);
        send(hgg_pkg::MODE_XOR, 3'd0, 10'd0, 10'd1023, 10'd2, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_XNOR, 3'd0, 10'd1, 10'd2, 10'd3, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_NOT, 3'd0, 10'd3, 10'd0, 10'd4, 32'h0, 32'h0,
             '0, '0, '0, '0);
        for (int i = 0; i < 8; i++)
            send(hgg_pkg::MODE_HALF, 3'(i), 10'd1, 10'd1023, 10'(5 + i),
                 (i % 2) ? 32'hffff_ffff : 32'h0, (i / 2 % 2) ? 32'hffff_ffff : 32'h0,
                 '0, '0, '0, '0);
        send(hgg_pkg::MODE_HALF, 3'd5, 10'd2, 10'd2, 10'd2, 32'h1234, 32'h7,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_COPY, 3'd0, 10'd6, 10'd0, 10'd6, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_COPY, 3'd0, 10'd5, 10'd0, 10'd1022, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_READ, 3'd0, 10'd0, 10'd0, 10'd0, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_READ, 3'd0, 10'd1023, 10'd0, 10'd0, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_READ, 3'd0, 10'd2, 10'd0, 10'd0, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_READ, 3'd0, 10'd1022, 10'd0, 10'd0, 32'h0, 32'h0,
             '0, '0, '0, '0);
        send(hgg_pkg::MODE_UNUSED, 3'd7, 10'd0, 10'd1, 10'd3, '1, '1, '1, '1, '1, '1);
        send(hgg_pkg::MODE_READ, 3'd0, 10'd3, 10'd0, 10'd0, 32'h0, 32'h0,
             '0, '0, '0, '0);
        settle();

        send_idle = 9;
        recv_idle = 72;
        set_config('1, '1, '1, '1);
        repeat (PHASE_ITEMS) send_random();
        settle();

        send_idle = 72;
        recv_idle = 9;
        set_config(64'h0, 64'h0, 64'h0, 64'h1);
        repeat (PHASE_ITEMS) send_random();
        settle();

        send_idle = 0;
        recv_idle = 0;
        set_config({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom} | 64'h1);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (PHASE_ITEMS) send_random();
        settle();

        $display("%0d items sent, %0d half-gates garbled, %0d result transfers checked",
                 items_sent, half_gates_seen, rows_checked);
        $display("four key/offset settings, stalls on both sides and one long output hold-off");
        if (errors == 0 && rows_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
